// File: design/pid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pid_pkg;

   localparam int OPCODE_W = 3;
   localparam int POSITION_W = 8;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 3;
   localparam int FOUND_W = 7;
   localparam int COUNT_OUT_W = 8;
   localparam int GROUP_SIZE = 8;

   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_APPENDED = 3'd5;

   typedef struct packed {
      logic shift_up;     // insert: cells at and above pos move up
      logic shift_down;   // delete: cells at and above pos take their upper neighbor
      logic load_cmp;     // search: every cell latches its key compare
   } pid_cell_ctrl_type;

endpackage

`default_nettype wire

// File: design/pid_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pid_req_if;
   import pid_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [OPCODE_W-1:0]         opcode;
   logic [POSITION_W-1:0]       position;
   logic signed [VALUE_W-1:0]   value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface pid_rsp_if;
   import pid_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [STATUS_W-1:0]         status;
   logic [FOUND_W-1:0]          found_index;
   logic signed [VALUE_W-1:0]   read_value;
   logic [COUNT_OUT_W-1:0]      entry_count;

   modport source (output valid, output status, output found_index, output read_value,
                   output entry_count, input ready);
   modport sink (input valid, input status, input found_index, input read_value,
                 input entry_count, output ready);
endinterface

`default_nettype wire

// File: design/pid_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pid_cell #(
   parameter int POS_W = 8
) (
   input  logic                                clock,
   input  pid_pkg::pid_cell_ctrl_type          ctrl,
   input  logic [POS_W-1:0]                    pos,
   input  logic [POS_W-1:0]                    idx,
   input  logic signed [pid_pkg::VALUE_W-1:0]  key,
   input  logic signed [pid_pkg::VALUE_W-1:0]  left_val,
   input  logic signed [pid_pkg::VALUE_W-1:0]  right_val,
   output logic signed [pid_pkg::VALUE_W-1:0]  val,
   output logic                                match
);
   import pid_pkg::*;

   logic signed [VALUE_W-1:0] val_ff;
   logic                      match_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift_up) begin
         if (idx == pos) begin
            val_ff <= key;
         end else if (idx > pos) begin
            val_ff <= left_val;
         end
      end else if (ctrl.shift_down) begin
         if (idx >= pos) begin
            val_ff <= right_val;
         end
      end
      if (ctrl.load_cmp) begin
         match_ff <= (val_ff == key);
      end
   end

   assign val = val_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// File: design/positional_insert_delete_array_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells, one entry per
// cell, with clear, insert, delete, search and read commands; each request transaction
// yields exactly one response transaction carrying a status and the entry count afterwards.
// Clear, insert, delete, read and unused opcodes, and a search of an empty list, end on
// the accepting edge: the whole row shifts in place and the response is registered then.
// A search latches the key compare in every cell on the accepting edge, then scans those
// match flags eight cells per cycle from the top valid group downward to a hit or group 0.
// One request is in flight at a time; a new request is taken once the response register is
// empty or being emptied.

module positional_insert_delete_array_unit #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   pid_req_if.sink     req_chan,
   pid_rsp_if.source   rsp_chan
);
   import pid_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
   localparam int NGRP  = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int NPAD  = NGRP * GROUP_SIZE;
   localparam int LIN_W = GRP_W + 3;

   typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [GRP_W-1:0]          grp_ff;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       status_ff;
   logic [FOUND_W-1:0]        fidx_ff;
   logic signed [VALUE_W-1:0] rval_ff;
   logic [COUNT_OUT_W-1:0]    ecnt_ff;

   logic                      accept;
   logic                      out_free;
   logic [POS_W-1:0]          pos_ext;
   logic [POS_W-1:0]          cnt_ext;
   logic [POS_W-1:0]          ins_pos;
   logic [POS_W-1:0]          cell_pos;
   logic                      full;
   logic                      empty;
   logic                      pos_valid;
   pid_cell_ctrl_type         cell_ctrl;

   logic signed [VALUE_W-1:0] cell_val [DEPTH];
   logic [NPAD-1:0]           match_vec;
   logic signed [VALUE_W-1:0] rd_val;

   // result of a command that completes on its accepting edge
   logic                      res_valid;
   logic                      go_scan;
   logic [STATUS_W-1:0]       res_status;
   logic [FOUND_W-1:0]        res_fidx;
   logic signed [VALUE_W-1:0] res_rval;
   logic [CNT_W-1:0]          count_in;
   logic [POS_W-1:0]          count_in_ext;

   logic [CNT_W-1:0]          cnt_m1;
   logic [31:0]               cnt_m1_32;
   logic [GRP_W-1:0]          grp_start;

   logic [GROUP_SIZE-1:0]     grp_bits;
   logic                      hit;
   logic [2:0]                hit_j;
   logic [LIN_W-1:0]          lin;
   logic [LIN_W-1:0]          hit_idx;
   logic [31:0]               hit_idx32;

   logic                      scan_done;
   logic                      rsp_set;
   logic                      rsp_valid_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !reset && (state_ff == ST_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign pos_ext = POS_W'(req_chan.position);
   assign cnt_ext = POS_W'(count_ff);
   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign pos_valid = (pos_ext < cnt_ext);
   assign ins_pos = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;

   assign cell_ctrl.shift_up   = accept && (req_chan.opcode == OP_INSERT) && !full;
   assign cell_ctrl.shift_down = accept && (req_chan.opcode == OP_DELETE) && !empty && pos_valid;
   assign cell_ctrl.load_cmp   = accept && (req_chan.opcode == OP_SEARCH);
   assign cell_pos = cell_ctrl.shift_up ? ins_pos : pos_ext;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_v;
      logic signed [VALUE_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = cell_val[i];
      end else begin : g_mid_l
         assign left_v = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_v = cell_val[i];
      end else begin : g_mid_r
         assign right_v = cell_val[i+1];
      end
      pid_cell #(
         .POS_W (POS_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .pos       (cell_pos),
         .idx       (POS_W'(i)),
         .key       (req_chan.value),
         .left_val  (left_v),
         .right_val (right_v),
         .val       (cell_val[i]),
         .match     (match_vec[i])
      );
   end

   for (genvar i = DEPTH; i < NPAD; i++) begin : g_pad
      assign match_vec[i] = 1'b0;
   end

   // only used when pos < count, so the low bits cover it
   assign rd_val = cell_val[pos_ext[IDX_W-1:0]];

   assign cnt_m1 = count_ff - 1'b1;
   assign cnt_m1_32 = 32'(cnt_m1);
   assign grp_start = GRP_W'(cnt_m1_32 >> 3);

   assign grp_bits = match_vec[{grp_ff, 3'b000} +: GROUP_SIZE];

   // highest flagged cell below count in the current group
   always_comb begin
      hit = 1'b0;
      hit_j = '0;
      lin = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
         lin = {grp_ff, 3'(j)};
         if (grp_bits[j] && (32'(lin) < 32'(count_ff))) begin
            hit = 1'b1;
            hit_j = 3'(j);
         end
      end
   end
   assign hit_idx = {grp_ff, hit_j};
   assign hit_idx32 = 32'(hit_idx);

   always_comb begin
      res_valid = 1'b1;
      go_scan = 1'b0;
      res_status = STAT_OK;
      res_fidx = '0;
      res_rval = '0;
      count_in = count_ff;
      case (req_chan.opcode)
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_INSERT: begin
            if (full) begin
               res_status = STAT_FULL;
            end else begin
               if (pos_ext > cnt_ext) begin
                  res_status = STAT_APPENDED;
               end
               count_in = CNT_W'(count_ff + 1'b1);
            end
         end
         OP_DELETE: begin
            if (empty) begin
               res_status = STAT_EMPTY;
            end else if (!pos_valid) begin
               res_status = STAT_BADPOS;
            end else begin
               count_in = CNT_W'(count_ff - 1'b1);
            end
         end
         OP_SEARCH: begin
            if (empty) begin
               res_status = STAT_EMPTY;
            end else begin
               res_valid = 1'b0;
               go_scan = 1'b1;
            end
         end
         OP_READ: begin
            if (empty) begin
               res_status = STAT_EMPTY;
            end else if (!pos_valid) begin
               res_status = STAT_BADPOS;
            end else begin
               res_fidx = req_chan.position[FOUND_W-1:0];
               res_rval = rd_val;
            end
         end
         default: begin
         end
      endcase
   end
   assign count_in_ext = POS_W'(count_in);

   assign scan_done = (state_ff == ST_SCAN) && (hit || (grp_ff == '0));
   assign rsp_set = ((state_ff == ST_IDLE) && accept && res_valid) || scan_done;
   assign rsp_valid_in = rsp_set || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  count_ff <= count_in;
                  if (go_scan) begin
                     grp_ff <= grp_start;
                     state_ff <= ST_SCAN;
                  end
                  if (res_valid) begin
                     status_ff <= res_status;
                     fidx_ff <= res_fidx;
                     rval_ff <= res_rval;
                     ecnt_ff <= count_in_ext[COUNT_OUT_W-1:0];
                  end
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  status_ff <= hit ? STAT_OK : STAT_NOTFOUND;
                  fidx_ff <= hit ? hit_idx32[FOUND_W-1:0] : '0;
                  rval_ff <= '0;
                  ecnt_ff <= cnt_ext[COUNT_OUT_W-1:0];
                  state_ff <= ST_IDLE;
               end else begin
                  grp_ff <= grp_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.found_index = fidx_ff;
   assign rsp_chan.read_value = rval_ff;
   assign rsp_chan.entry_count = ecnt_ff;

endmodule

`default_nettype wire

// File: design/pid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pid_checker #(
   parameter int DEPTH = 128
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [pid_pkg::OPCODE_W-1:0]         req_opcode,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [pid_pkg::STATUS_W-1:0]         rsp_status,
   input logic [pid_pkg::FOUND_W-1:0]          rsp_found_index,
   input logic signed [pid_pkg::VALUE_W-1:0]   rsp_read_value,
   input logic [pid_pkg::COUNT_OUT_W-1:0]      rsp_entry_count
);
   import pid_pkg::*;

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one transaction in flight: no request taken over a stalled response
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !(rsp_valid && !rsp_ready))
      else $error("request accepted while response stalled");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_CLEAR)
      |=> rsp_valid && (rsp_status == STAT_OK) && (rsp_entry_count == '0))
      else $error("clear did not answer next cycle with an empty list");

   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK)
      |-> (rsp_found_index == '0) && (rsp_read_value == '0))
      else $error("failed command returned index or data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL)
      |-> (rsp_entry_count == COUNT_OUT_W'(DEPTH)))
      else $error("full status with a count other than the capacity");

endmodule

bind positional_insert_delete_array_unit pid_checker #(
   .DEPTH (DEPTH)
) u_pid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_opcode      (req_chan.opcode),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_found_index (rsp_chan.found_index),
   .rsp_read_value  (rsp_chan.read_value),
   .rsp_entry_count (rsp_chan.entry_count)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import pid_pkg::*;

   localparam int DEPTH = 128;
   localparam int PHASE_ITEMS = 65;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_MID   = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic [POSITION_W-1:0]     position;
      logic signed [VALUE_W-1:0] value;
   } list_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [FOUND_W-1:0]        found_index;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_OUT_W-1:0]    entry_count;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pid_req_if req_chan ();
   pid_rsp_if rsp_chan ();

   positional_insert_delete_array_unit #(.DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   list_cmd_type cmd_q[$];
   list_rsp_type expected_rsp_q[$];
   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int gen_count;

   // shadow copy of the list
   logic signed [VALUE_W-1:0] list_mem [DEPTH];
   int list_count;

   function automatic list_rsp_type predict_list_op(logic [OPCODE_W-1:0] op,
                                                    logic [POSITION_W-1:0] pos_in,
                                                    logic signed [VALUE_W-1:0] val);
      list_rsp_type r;
      int pos;
      bit hit;
      r.status = STAT_OK;
      r.found_index = '0;
      r.read_value = '0;
      pos = int'(pos_in);
      hit = 1'b0;
      case (op)
         OP_CLEAR: begin
            list_count = 0;
         end
         OP_INSERT: begin
            if (list_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               if (pos > list_count) begin
                  pos = list_count;
                  r.status = STAT_APPENDED;
               end
               for (int i = list_count; i > pos; i--)
                  list_mem[i] = list_mem[i-1];
               list_mem[pos] = val;
               list_count++;
            end
         end
         OP_DELETE: begin
            if (list_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (pos >= list_count) begin
               r.status = STAT_BADPOS;
            end else begin
               for (int i = pos; i + 1 < list_count; i++)
                  list_mem[i] = list_mem[i+1];
               list_count--;
            end
         end
         OP_SEARCH: begin
            if (list_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.status = STAT_NOTFOUND;
               // highest matching index wins
               for (int i = list_count - 1; i >= 0 && !hit; i--) begin
                  if (list_mem[i] == val) begin
                     hit = 1'b1;
                     r.status = STAT_OK;
                     r.found_index = i[FOUND_W-1:0];
                  end
               end
            end
         end
         OP_READ: begin
            if (list_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (pos >= list_count) begin
               r.status = STAT_BADPOS;
            end else begin
               r.found_index = pos[FOUND_W-1:0];
               r.read_value = list_mem[pos];
            end
         end
         default: ;
      endcase
      r.entry_count = list_count[COUNT_OUT_W-1:0];
      return r;
   endfunction

   // stimulus generation; gen_count tracks the count only to shape positions
   task automatic push_cmd(logic [OPCODE_W-1:0] op, logic [POSITION_W-1:0] pos,
                           logic signed [VALUE_W-1:0] val);
      cmd_q.push_back('{op, pos, val});
      case (op)
         OP_CLEAR: gen_count = 0;
         OP_INSERT: if (gen_count < DEPTH) gen_count++;
         OP_DELETE: if (gen_count > 0 && pos < gen_count) gen_count--;
         default: ;
      endcase
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] pool [8];
      pool = '{0, 1, -1, 7, 42, -100, 32'sh7fffffff, 32'sh80000000};
      if ($urandom_range(99) < 50)
         return pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic logic [POSITION_W-1:0] pick_position();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70)
         return POSITION_W'($urandom_range(gen_count));
      if (sel < 90)
         return POSITION_W'($urandom_range(255));
      case ($urandom_range(3))
         0: return '0;
         1: return (gen_count > 0) ? POSITION_W'(gen_count - 1) : '0;
         2: return POSITION_W'(gen_count);
         default: return POSITION_W'(255);
      endcase
   endfunction

   task automatic gen_load(int n);
      push_cmd(OP_CLEAR, POSITION_W'($urandom_range(255)), $urandom);
      repeat (n) begin
         if ($urandom_range(1))
            push_cmd(OP_INSERT, POSITION_W'(gen_count), pick_value());
         else
            push_cmd(OP_INSERT, POSITION_W'($urandom_range(255, gen_count)), pick_value());
      end
   endtask

   task automatic gen_random(int n);
      int sel;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(99);
         if (sel < 3) begin
            gen_load($urandom_range(24));
         end else if (sel < 33) begin
            push_cmd(OP_INSERT, pick_position(), pick_value());
         end else if (sel < 53) begin
            push_cmd(OP_DELETE, pick_position(), pick_value());
         end else if (sel < 77) begin
            push_cmd(OP_SEARCH, pick_position(), pick_value());
         end else if (sel < 95) begin
            push_cmd(OP_READ, pick_position(), pick_value());
         end else if (sel < 97) begin
            push_cmd(OP_CLEAR, pick_position(), pick_value());
         end else begin
            push_cmd(OPCODE_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                     pick_position(), pick_value());
         end
      end
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (cmd_q.size() != 0 || expected_rsp_q.size() != 0 || req_chan.valid);
      @(negedge clock);
   endtask

   task automatic check_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_rsp_q.push_back(predict_list_op(req_chan.opcode, req_chan.position,
                                                     req_chan.value));
         if (!req_chan.valid || req_chan.ready) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid <= 1'b1;
               req_chan.opcode <= cmd_q[0].opcode;
               req_chan.position <= cmd_q[0].position;
               req_chan.value <= cmd_q[0].value;
               void'(cmd_q.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      list_rsp_type exp_rsp;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response transaction, status %0d count %0d", $time,
                        rsp_chan.status, rsp_chan.entry_count);
               error_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("status", exp_rsp.status, rsp_chan.status);
               check_field("found_index", exp_rsp.found_index, rsp_chan.found_index);
               check_field("read_value", exp_rsp.read_value, rsp_chan.read_value);
               check_field("entry_count", exp_rsp.entry_count, rsp_chan.entry_count);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_CLEAR;
      req_chan.position = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      list_count = 0;
      gen_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list cases, extremes, append, duplicates, bad positions
      push_cmd(OP_READ, 0, 0);
      push_cmd(OP_DELETE, 0, 0);
      push_cmd(OP_SEARCH, 0, 0);
      push_cmd(OP_INSERT, 0, 32'sh7fffffff);
      push_cmd(OP_INSERT, 255, 32'sh80000000);
      push_cmd(OP_INSERT, 0, 0);
      push_cmd(OP_INSERT, 1, -1);
      push_cmd(OP_INSERT, 200, 5);
      push_cmd(OP_INSERT, 5, -1);
      push_cmd(OP_SEARCH, 0, 32'sh7fffffff);
      push_cmd(OP_SEARCH, 255, -1);
      push_cmd(OP_SEARCH, 0, 12345);
      push_cmd(OP_READ, 0, 0);
      push_cmd(OP_READ, 5, 0);
      push_cmd(OP_READ, 6, 0);
      push_cmd(OP_READ, 255, 0);
      push_cmd(OP_DELETE, 255, 0);
      push_cmd(OP_DELETE, 0, 0);
      push_cmd(OP_DELETE, 4, 0);
      push_cmd(OP_UNUSED_FIRST, 255, 32'sh80000000);
      push_cmd(OP_UNUSED_MID, 0, -1);
      push_cmd(OP_UNUSED_LAST, 128, 32'sh7fffffff);
      push_cmd(OP_CLEAR, 255, -1);
      push_cmd(OP_READ, 0, 0);
      push_cmd(OP_SEARCH, 0, 0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         // odd phases start from a full list
         gen_load((phase % 2) ? DEPTH : $urandom_range(60));
         gen_random(PHASE_ITEMS);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

// File: files.f
design/pid_pkg.sv
design/pid_if.sv
design/pid_cell.sv
design/positional_insert_delete_array_unit.sv
design/pid_checker.sv
tb/tb.sv
